// File: design/plsbe_pkg.sv
package plsbe_pkg;

	localparam int LANES      = 8;
	localparam int BITS       = 8;
	localparam int DATA_W     = 64;
	localparam int LEVEL_W    = 8;
	localparam int TICK_W     = 8;
	localparam int BITNUM_W   = 3;
	localparam int PHASE_W    = 2;
	localparam int TDATA_W    = 24;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [BITNUM_W-1:0] TOP_BIT = BITNUM_W'(BITS - 1);

	localparam logic [TICK_W-1:0] HIGH_TICKS_RST   = TICK_W'(6);
	localparam logic [TICK_W-1:0] EXTEND_TICKS_RST = TICK_W'(18);
	localparam logic [TICK_W-1:0] LOW_TICKS_RST    = TICK_W'(6);

	typedef logic [LANES-1:0] lanes_t;
	typedef logic [BITS-1:0][LANES-1:0] planes_t;

	typedef struct packed {
		planes_t planes;
		logic    frame_end;
	} column_t;

	typedef struct packed {
		logic    valid;
		column_t column;
	} queue_head_t;

	typedef struct packed {
		lanes_t              lane_enable;
		logic [TICK_W-1:0]   high_ticks;
		logic [TICK_W-1:0]   extend_ticks;
		logic [TICK_W-1:0]   low_ticks;
	} cfg_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LANE_ENABLE  = CFG_IDX_W'(0),
		REG_HIGH_TICKS   = CFG_IDX_W'(1),
		REG_EXTEND_TICKS = CFG_IDX_W'(2),
		REG_LOW_TICKS    = CFG_IDX_W'(3)
	} reg_idx_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_HIGH   = 2'd0,
		PH_EXTEND = 2'd1,
		PH_LOW    = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		SEG_HIGH   = 3'b001,
		SEG_EXTEND = 3'b010,
		SEG_LOW    = 3'b100
	} seg_state_t;

	// A tick count of zero is held for the shortest length instead.
	function automatic logic [TICK_W-1:0] clamp_ticks(input logic [CFG_DATA_W-1:0] t);
		return (t == '0) ? TICK_W'(1) : TICK_W'(t);
	endfunction

endpackage

// File: design/plsbe_cfg.sv
module plsbe_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [plsbe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [plsbe_pkg::CFG_DATA_W-1:0] cfg_data,
	output plsbe_pkg::cfg_t                  cfg
);
	import plsbe_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Tick registers hold the clamped length, so the sequencer uses them directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lane_enable  <= '0;
			cfg_q.high_ticks   <= HIGH_TICKS_RST;
			cfg_q.extend_ticks <= EXTEND_TICKS_RST;
			cfg_q.low_ticks    <= LOW_TICKS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LANE_ENABLE:  cfg_q.lane_enable  <= cfg_data[LANES-1:0];
				REG_HIGH_TICKS:   cfg_q.high_ticks   <= clamp_ticks(cfg_data);
				REG_EXTEND_TICKS: cfg_q.extend_ticks <= clamp_ticks(cfg_data);
				REG_LOW_TICKS:    cfg_q.low_ticks    <= clamp_ticks(cfg_data);
				default: ;
			endcase
		end
	end

endmodule

// File: design/plsbe_front.sv
module plsbe_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [plsbe_pkg::DATA_W-1:0] s_tdata,
	input  logic                        s_tlast,
	output plsbe_pkg::queue_head_t      head,
	input  logic                        pop
);
	import plsbe_pkg::*;

	column_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	column_t           col_in;
	logic              push;
	logic              do_pop;

	// Turn the byte column into bit planes: plane b holds bit b of every lane.
	always_comb begin
		col_in.frame_end = s_tlast;
		for (int b = 0; b < BITS; b++) begin
			for (int k = 0; k < LANES; k++) begin
				col_in.planes[b][k] = s_tdata[8 * k + b];
			end
		end
	end

	assign s_tready    = (count_q != QCNT_W'(QDEPTH));
	assign push        = s_tvalid && s_tready;
	assign do_pop      = pop && (count_q != '0);
	assign head.valid  = (count_q != '0);
	assign head.column = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= col_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/plsbe_back.sv
module plsbe_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  plsbe_pkg::cfg_t               cfg,
	input  plsbe_pkg::queue_head_t        head,
	output logic                         pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [plsbe_pkg::TDATA_W-1:0] m_tdata,
	output logic                         m_tlast,
	output logic                         m_tuser
);
	import plsbe_pkg::*;

	seg_state_t          seg_q;
	logic [BITNUM_W-1:0] bit_q;
	logic                m_valid_q;
	lanes_t              levels_q;
	logic [TICK_W-1:0]   hold_q;
	logic [BITNUM_W-1:0] bitn_q;
	phase_t              phase_q;
	logic                last_q;
	logic                flast_q;

	logic                load;
	logic                seg_last;
	lanes_t              lv_next;
	logic [TICK_W-1:0]   hold_next;
	phase_t              phase_next;
	logic [LEVEL_W-1:0]  levels_ext;

	assign load     = head.valid && (!m_valid_q || m_tready);
	assign seg_last = (seg_q == SEG_LOW) && (bit_q == '0);
	// The queue head is the column in progress; it leaves with its final segment.
	assign pop      = load && seg_last;

	always_comb begin
		unique case (seg_q)
			SEG_HIGH: begin
				lv_next    = cfg.lane_enable;
				hold_next  = cfg.high_ticks;
				phase_next = PH_HIGH;
			end
			SEG_EXTEND: begin
				lv_next    = head.column.planes[bit_q] & cfg.lane_enable;
				hold_next  = cfg.extend_ticks;
				phase_next = PH_EXTEND;
			end
			SEG_LOW: begin
				lv_next    = '0;
				hold_next  = cfg.low_ticks;
				phase_next = PH_LOW;
			end
			default: begin
				lv_next    = '0;
				hold_next  = cfg.low_ticks;
				phase_next = PH_LOW;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			seg_q     <= SEG_HIGH;
			bit_q     <= TOP_BIT;
		end else if (load) begin
			m_valid_q <= 1'b1;
			unique case (seg_q)
				SEG_HIGH:   seg_q <= SEG_EXTEND;
				SEG_EXTEND: seg_q <= SEG_LOW;
				SEG_LOW: begin
					seg_q <= SEG_HIGH;
					bit_q <= seg_last ? TOP_BIT : bit_q - 1'b1;
				end
				default:    seg_q <= SEG_HIGH;
			endcase
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			levels_q <= lv_next;
			hold_q   <= hold_next;
			bitn_q   <= bit_q;
			phase_q  <= phase_next;
			last_q   <= seg_last;
			flast_q  <= seg_last && head.column.frame_end;
		end
	end

	always_comb begin
		levels_ext              = '0;
		levels_ext[LANES-1:0]   = levels_q;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, phase_q, bitn_q, hold_q, levels_ext};
	assign m_tlast  = last_q;
	assign m_tuser  = flast_q;

endmodule

// File: design/parallel_led_strip_bit_encoder.sv
// An accepted column is written into the queue, then loaded into the back-end output registers.
// Throughput: a column is 24 segments, one segment per cycle from the back-end sequencer;
// columns follow each other without gaps while the output keeps taking words.
// A two-entry queue between front and back lets the input take columns during stalls.
// Reset: control registers return to their reset values, the queue empties and no word is shown.
module parallel_led_strip_bit_encoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [plsbe_pkg::DATA_W-1:0]     s_tdata,   // lane_bytes
	input  logic                            s_tlast,   // frame_end
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [plsbe_pkg::TDATA_W-1:0]    m_tdata,   // line_levels, hold_ticks, bit_number, phase
	output logic                            m_tlast,   // run_last
	output logic                            m_tuser,   // frame_last
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [plsbe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [plsbe_pkg::CFG_DATA_W-1:0] cfg_data
);
	import plsbe_pkg::*;

	cfg_t        cfg;
	queue_head_t head;
	logic        pop;

	plsbe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	plsbe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.head     (head),
		.pop      (pop)
	);

	plsbe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	a_last_is_final_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[20:19] == PH_LOW) && (m_tdata[18:16] == 3'd0))
		else $error("last word of a column is not the low segment of bit 0");

	a_frame_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame marker on a word that does not close its column");

	a_low_all_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[20:19] == PH_LOW) |-> (m_tdata[7:0] == 8'd0))
		else $error("lane driven high during the low segment");

	a_hold_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:8] != 8'd0) && (m_tdata[20:19] != 2'd3))
		else $error("zero hold length or unknown phase on output");

	a_pop_only_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid && (!m_tvalid || m_tready))
		else $error("queue popped while the output word is stalled");

endmodule
